// ===== rtl/core/packet_framer_crc16_core_macros.svh =====
`ifndef PACKET_FRAMER_CRC16_CORE_MACROS_SVH
`define PACKET_FRAMER_CRC16_CORE_MACROS_SVH

`ifndef SYNTH

// prop holds at every clock edge outside reset
`define PKFR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pkfr assertion failed");

// cond never holds outside reset
`define PKFR_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("pkfr forbidden condition");

`else

`define PKFR_ASSERT(lbl, clk, rst_n, prop)
`define PKFR_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ===== rtl/core/pkfr_pkg.sv =====
package pkfr_pkg;

  localparam logic OP_START   = 1'b0;
  localparam logic OP_PAYLOAD = 1'b1;

  localparam logic [15:0] MAX_PAYLOAD = 16'd255;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [15:0] CRC_INIT    = 16'h0000;

  localparam int unsigned FIFO_DEPTH_DEF = 4;

  typedef struct packed {
    logic        op;
    logic [7:0]  version;
    logic [15:0] packet_id;
    logic [15:0] sequence_req;
    logic [15:0] length;
    logic [7:0]  data_byte;
    logic        is_final;
  } cmd_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/packet_framer_crc16_core.sv =====
// Packet framer with CRC-16 (poly 0x1021, init 0).
// Input channel (in_*): operation 0 opens a packet with version, id, sequence
//   and length (clamped to 255); operation 1 carries one payload byte. Payload
//   bytes with no packet open are accepted and dropped.
// Output channel (out_*): one wire byte per transaction: sync word, version,
//   id, sequence, length (16-bit fields low byte first), payload, then the CRC
//   low byte and high byte; out_last marks the CRC high byte.
// Config channel (cfg_*): writes the 16-bit sync word; write it only while
//   the block is idle. Always ready.
// Path: input is queued; each wire byte is registered in the output register.
// Throughput: the output emits one byte per cycle while out_ready is high; a
//   start transaction yields 9 wire bytes (11 with empty payload), a payload
//   byte one (three on the final byte). A command queue of FIFO_DEPTH entries
//   absorbs input while header bursts drain; in_ready drops only when it is full.
// Stall: with out_ready low the output byte holds and the queue fills.
// Reset: synchronous, active low; clears the sync word, closes any packet
//   and empties the queue and the output register.
module packet_framer_crc16_core #(
  parameter int unsigned FIFO_DEPTH = pkfr_pkg::FIFO_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [7:0]  in_version,
  input  logic [15:0] in_packet_id,
  input  logic [15:0] in_sequence_req,
  input  logic [15:0] in_payload_length,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_wire_byte,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic [15:0]    sync_word_r;
  logic           q_full, q_empty, q_push, q_pop;
  pkfr_pkg::cmd_t q_wdata, q_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_word_r <= 16'd0;
    end else if (cfg_valid && cfg_ready) begin
      sync_word_r <= cfg_data;
    end
  end

  pkfr_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_version        (in_version),
    .in_packet_id      (in_packet_id),
    .in_sequence_req   (in_sequence_req),
    .in_payload_length (in_payload_length),
    .in_data_byte      (in_data_byte),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_wdata           (q_wdata)
  );

  pkfr_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  pkfr_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .sync_word     (sync_word_r),
    .head          (q_rdata),
    .head_valid    (!q_empty),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_wire_byte (out_wire_byte),
    .out_last      (out_last)
  );

endmodule

// ===== rtl/core/pkfr_front.sv =====
`include "packet_framer_crc16_core_macros.svh"

module pkfr_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_operation,
  input  logic [7:0]         in_version,
  input  logic [15:0]        in_packet_id,
  input  logic [15:0]        in_sequence_req,
  input  logic [15:0]        in_payload_length,
  input  logic [7:0]         in_data_byte,
  input  logic               q_full,
  output logic               q_push,
  output pkfr_pkg::cmd_t     q_wdata
);

  logic        open_r, open_nxt;
  logic [15:0] left_r, left_nxt;
  logic [15:0] len_clamped;
  logic        accept;

  assign in_ready    = !q_full;
  assign accept      = in_valid && in_ready;
  assign len_clamped = (in_payload_length > pkfr_pkg::MAX_PAYLOAD) ?
                       pkfr_pkg::MAX_PAYLOAD : in_payload_length;

  always_comb begin
    open_nxt              = open_r;
    left_nxt              = left_r;
    q_push                = 1'b0;
    q_wdata.op            = in_operation;
    q_wdata.version       = in_version;
    q_wdata.packet_id     = in_packet_id;
    q_wdata.sequence_req  = in_sequence_req;
    q_wdata.length        = len_clamped;
    q_wdata.data_byte     = in_data_byte;
    q_wdata.is_final      = 1'b0;
    if (accept) begin
      if (in_operation == pkfr_pkg::OP_START) begin
        q_push   = 1'b1;
        left_nxt = len_clamped;
        open_nxt = (len_clamped != 16'd0);
      end else if (open_r) begin
        q_push           = 1'b1;
        q_wdata.is_final = (left_r == 16'd1);
        left_nxt         = left_r - 16'd1;
        open_nxt         = (left_r != 16'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      left_r <= 16'd0;
    end else begin
      open_r <= open_nxt;
      left_r <= left_nxt;
    end
  end

  // an open packet always expects at least one more byte
  `PKFR_ASSERT(a_open_has_bytes, clk, rst_n, open_r |-> (left_r != 16'd0))
  `PKFR_ASSERT_NEVER(a_push_when_full, clk, rst_n, q_push && q_full)

endmodule

// ===== rtl/core/pkfr_fifo.sv =====
`include "packet_framer_crc16_core_macros.svh"

module pkfr_fifo #(
  parameter int unsigned DEPTH = pkfr_pkg::FIFO_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pkfr_pkg::cmd_t wdata,
  output logic           full,
  input  logic           pop,
  output pkfr_pkg::cmd_t rdata,
  output logic           empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  pkfr_pkg::cmd_t mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  count_r;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  `PKFR_ASSERT_NEVER(a_pop_empty, clk, rst_n, pop && empty)

endmodule

// ===== rtl/core/pkfr_back.sv =====
`include "packet_framer_crc16_core_macros.svh"

module pkfr_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [15:0]    sync_word,
  input  pkfr_pkg::cmd_t head,
  input  logic           head_valid,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_wire_byte,
  output logic           out_last
);

  localparam logic [3:0] STEP_SYNC_LO = 4'd0;
  localparam logic [3:0] STEP_SYNC_HI = 4'd1;
  localparam logic [3:0] STEP_VER     = 4'd2;
  localparam logic [3:0] STEP_ID_LO   = 4'd3;
  localparam logic [3:0] STEP_ID_HI   = 4'd4;
  localparam logic [3:0] STEP_SEQ_LO  = 4'd5;
  localparam logic [3:0] STEP_SEQ_HI  = 4'd6;
  localparam logic [3:0] STEP_LEN_LO  = 4'd7;
  localparam logic [3:0] STEP_LEN_HI  = 4'd8;
  localparam logic [3:0] STEP_DATA    = 4'd9;
  localparam logic [3:0] STEP_CRC_LO  = 4'd10;
  localparam logic [3:0] STEP_CRC_HI  = 4'd11;

  logic        mid_r, mid_nxt;
  logic [3:0]  step_r, step_nxt;
  logic [15:0] crc_r;
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_last_r;

  logic [3:0]  step;
  logic [7:0]  byte_sel;
  logic        hashed;
  logic        done;
  logic        fire;

  assign step = mid_r ? step_r :
                ((head.op == pkfr_pkg::OP_START) ? STEP_SYNC_LO : STEP_DATA);
  assign fire = head_valid && (!out_valid_r || out_ready);
  assign pop  = fire && done;

  always_comb begin
    byte_sel = 8'h00;
    hashed   = 1'b0;
    done     = 1'b0;
    step_nxt = step + 4'd1;
    case (step)
      STEP_SYNC_LO: byte_sel = sync_word[7:0];
      STEP_SYNC_HI: byte_sel = sync_word[15:8];
      STEP_VER: begin
        byte_sel = head.version;
        hashed   = 1'b1;
      end
      STEP_ID_LO: begin
        byte_sel = head.packet_id[7:0];
        hashed   = 1'b1;
      end
      STEP_ID_HI: begin
        byte_sel = head.packet_id[15:8];
        hashed   = 1'b1;
      end
      STEP_SEQ_LO: begin
        byte_sel = head.sequence_req[7:0];
        hashed   = 1'b1;
      end
      STEP_SEQ_HI: begin
        byte_sel = head.sequence_req[15:8];
        hashed   = 1'b1;
      end
      STEP_LEN_LO: begin
        byte_sel = head.length[7:0];
        hashed   = 1'b1;
      end
      STEP_LEN_HI: begin
        byte_sel = head.length[15:8];
        hashed   = 1'b1;
        done     = (head.length != 16'd0);
        step_nxt = STEP_CRC_LO;
      end
      STEP_DATA: begin
        byte_sel = head.data_byte;
        hashed   = 1'b1;
        done     = !head.is_final;
        step_nxt = STEP_CRC_LO;
      end
      STEP_CRC_LO: byte_sel = crc_r[7:0];
      STEP_CRC_HI: begin
        byte_sel = crc_r[15:8];
        done     = 1'b1;
      end
      default: begin
        byte_sel = 8'h00;
        done     = 1'b1;
      end
    endcase
    mid_nxt = !done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r       <= 1'b0;
      step_r      <= STEP_SYNC_LO;
      crc_r       <= pkfr_pkg::CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        mid_r       <= mid_nxt;
        step_r      <= step_nxt;
        out_valid_r <= 1'b1;
        if (hashed) begin
          crc_r <= pkfr_pkg::crc_byte((step == STEP_VER) ? pkfr_pkg::CRC_INIT : crc_r,
                                      byte_sel);
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte_r <= byte_sel;
      out_last_r <= (step == STEP_CRC_HI);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_wire_byte = out_byte_r;
  assign out_last      = out_last_r;

  // a half-sent entry stays at the queue head
  `PKFR_ASSERT(a_mid_has_head, clk, rst_n, mid_r |-> head_valid)
  `PKFR_ASSERT(a_end_closes, clk, rst_n, (fire && (step == STEP_CRC_HI)) |=> !mid_r)
  `PKFR_ASSERT(a_crc_after_hash, clk, rst_n,
    (mid_r && (step_r == STEP_CRC_LO)) |->
      ((head.op == pkfr_pkg::OP_START) ? (head.length == 16'd0) : head.is_final))

endmodule

// ===== tb/sv/pkfr_frame_checker.sv =====
module pkfr_frame_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_operation,
  input  logic [7:0]  in_version,
  input  logic [15:0] in_packet_id,
  input  logic [15:0] in_sequence_req,
  input  logic [15:0] in_payload_length,
  input  logic [7:0]  in_data_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_wire_byte,
  input  logic        out_last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          bytes_pending,
  output int          bytes_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] wire_byte;
    logic       last;
  } wire_beat_t;

  wire_beat_t  wire_due[$];
  logic [15:0] sync_copy;
  logic [15:0] crc_run;
  logic [15:0] bytes_left;
  logic        pkt_open;
  int          fail_count    = 0;
  int          checked_count = 0;

  // bitwise form, MSB first, no reflection
  function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r  = {r[14:0], 1'b0} ^ (fb ? pkfr_pkg::CRC_POLY : 16'h0000);
    end
    return r;
  endfunction

  task automatic emit(input logic [7:0] b, input logic fin);
    wire_due.push_back('{wire_byte: b, last: fin});
  endtask

  task automatic emit_hashed(input logic [7:0] b);
    crc_run = crc_next(crc_run, b);
    emit(b, 1'b0);
  endtask

  task automatic emit_crc();
    emit(crc_run[7:0], 1'b0);
    emit(crc_run[15:8], 1'b1);
    pkt_open   = 1'b0;
    bytes_left = '0;
  endtask

  task automatic frame_transaction();
    logic [15:0] len;
    if (in_operation == pkfr_pkg::OP_START) begin
      len = (in_payload_length > pkfr_pkg::MAX_PAYLOAD) ?
            pkfr_pkg::MAX_PAYLOAD : in_payload_length;
      crc_run = pkfr_pkg::CRC_INIT;
      emit(sync_copy[7:0], 1'b0);
      emit(sync_copy[15:8], 1'b0);
      emit_hashed(in_version);
      emit_hashed(in_packet_id[7:0]);
      emit_hashed(in_packet_id[15:8]);
      emit_hashed(in_sequence_req[7:0]);
      emit_hashed(in_sequence_req[15:8]);
      emit_hashed(len[7:0]);
      emit_hashed(len[15:8]);
      bytes_left = len;
      pkt_open   = 1'b1;
      if (len == 0) emit_crc();
    end else if (pkt_open) begin
      emit_hashed(in_data_byte);
      if (bytes_left > 0) bytes_left--;
      if (bytes_left == 0) emit_crc();
    end
  endtask

  always @(posedge clk) begin : watch
    wire_beat_t due;
    if (!rst_n) begin
      sync_copy  = 16'h0000;
      crc_run    = pkfr_pkg::CRC_INIT;
      bytes_left = '0;
      pkt_open   = 1'b0;
      wire_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (wire_due.size() == 0) begin
          fail_count++;
          $error("wire_byte: expected no transaction, got %02h (last %0b)",
                 out_wire_byte, out_last);
        end else begin
          due = wire_due.pop_front();
          checked_count++;
          if (out_wire_byte !== due.wire_byte) begin
            fail_count++;
            $error("wire_byte: expected %02h, got %02h", due.wire_byte, out_wire_byte);
          end
          if (out_last !== due.last) begin
            fail_count++;
            $error("last: expected %0b, got %0b", due.last, out_last);
          end
        end
      end
      if (cfg_valid && cfg_ready) sync_copy = cfg_data;
      if (in_valid && in_ready) frame_transaction();
    end
    mismatches    <= fail_count;
    bytes_pending <= wire_due.size();
    bytes_checked <= checked_count;
  end

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF        = 6;
  localparam int RESET_CYCLES    = 6;
  localparam int ITEM_TARGET     = 460;
  localparam int HOLD_OFF_CYCLES = 160;
  localparam int DRAIN_CYCLES    = 8;
  localparam int TAIL_CYCLES     = 16;
  localparam int CYCLE_LIMIT     = 200000;

  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_SLOW, RX_PATTERN} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_operation;
  logic [7:0]  in_version;
  logic [15:0] in_packet_id;
  logic [15:0] in_sequence_req;
  logic [15:0] in_payload_length;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_wire_byte;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  int       mismatches;
  int       bytes_pending;
  int       bytes_checked;
  int       cycle_count    = 0;
  rx_mode_t rx_mode;
  int       hold_off_asked;

  // sender state
  int burst_left   = 0;
  int burst_max    = 1;
  int gap_max      = 0;
  int open_left    = 0;
  int items_sent   = 0;
  int starts_sent  = 0;
  int strays_sent  = 0;

  always #(CLK_HALF) clk = ~clk;

  packet_framer_crc16_core uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_version        (in_version),
    .in_packet_id      (in_packet_id),
    .in_sequence_req   (in_sequence_req),
    .in_payload_length (in_payload_length),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_wire_byte     (out_wire_byte),
    .out_last          (out_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  pkfr_frame_checker frame_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_version        (in_version),
    .in_packet_id      (in_packet_id),
    .in_sequence_req   (in_sequence_req),
    .in_payload_length (in_payload_length),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_wire_byte     (out_wire_byte),
    .out_last          (out_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .mismatches        (mismatches),
    .bytes_pending     (bytes_pending),
    .bytes_checked     (bytes_checked)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // receiver: own stall pattern, plus a long hold-off on request
  initial begin
    int hold_off_seen;
    int hold_left;
    int beat;
    hold_off_seen = 0;
    hold_left     = 0;
    beat          = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      beat++;
      if (hold_left == 0 && hold_off_asked != hold_off_seen) begin
        hold_off_seen = hold_off_asked;
        hold_left     = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS:  out_ready <= 1'b1;
          RX_RANDOM:  out_ready <= ($urandom_range(0, 9) < 7);
          RX_SLOW:    out_ready <= ($urandom_range(0, 3) == 0);
          default:    out_ready <= ((beat % 5) < 2);
        endcase
      end
    end
  end

  task automatic send_item(input logic op, input logic [7:0] ver, input logic [15:0] id,
                           input logic [15:0] seq, input logic [15:0] len,
                           input logic [7:0] data);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, burst_max);
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid          <= 1'b1;
    in_operation      <= op;
    in_version        <= ver;
    in_packet_id      <= id;
    in_sequence_req   <= seq;
    in_payload_length <= len;
    in_data_byte      <= data;
    do @(posedge clk); while (!in_ready);
    // ignored payload bytes are not counted as items
    if (op == pkfr_pkg::OP_START) begin
      starts_sent++;
      items_sent++;
      open_left = int'((len > pkfr_pkg::MAX_PAYLOAD) ? pkfr_pkg::MAX_PAYLOAD : len);
    end else if (open_left > 0) begin
      open_left--;
      items_sent++;
    end else begin
      strays_sent++;
    end
  endtask

  task automatic send_start(input logic [7:0] ver, input logic [15:0] id,
                            input logic [15:0] seq, input logic [15:0] len);
    send_item(pkfr_pkg::OP_START, ver, id, seq, len, 8'($urandom));
  endtask

  task automatic send_payload(input logic [7:0] data);
    send_item(pkfr_pkg::OP_PAYLOAD, 8'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), data);
  endtask

  task automatic write_sync(input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // stop offering and let the block drain completely
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (bytes_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // mostly well-formed packets, some cut short or overrun, some stray bytes
  task automatic random_traffic(input int count);
    int          stop_at;
    int          roll;
    int          n_payload;
    int          clamped;
    logic [15:0] len;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        repeat ($urandom_range(1, 3)) send_payload(8'($urandom));
      end else begin
        case ($urandom_range(0, 9))
          0:       len = 16'h0000;
          1, 2:    len = 16'($urandom_range(7, 32));
          3:       len = 16'($urandom);
          default: len = 16'($urandom_range(1, 6));
        endcase
        clamped = int'((len > pkfr_pkg::MAX_PAYLOAD) ? pkfr_pkg::MAX_PAYLOAD : len);
        if (roll < 80 && clamped <= 40) begin
          n_payload = clamped;
        end else if (roll < 90 || clamped > 40) begin
          n_payload = $urandom_range(0, (clamped > 8) ? 8 : clamped);
        end else begin
          n_payload = clamped + $urandom_range(1, 3);
        end
        send_start(8'($urandom), 16'($urandom), 16'($urandom), len);
        repeat (n_payload) send_payload(8'($urandom));
      end
    end
  endtask

  initial begin
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_operation      <= pkfr_pkg::OP_START;
    in_version        <= '0;
    in_packet_id      <= '0;
    in_sequence_req   <= '0;
    in_payload_length <= '0;
    in_data_byte      <= '0;
    cfg_valid         <= 1'b0;
    cfg_data          <= '0;
    rx_mode           <= RX_ALWAYS;
    hold_off_asked    <= 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed
    write_sync(16'hFFFF);
    rx_mode   <= RX_RANDOM;
    gap_max   = 3;
    burst_max = 6;
    send_payload(8'hFF);                              // nothing open after reset
    send_start(8'h00, 16'h0000, 16'h0000, 16'h0000);  // empty payload
    send_start(8'hFF, 16'hFFFF, 16'hFFFF, 16'h0000);
    send_start(8'h01, 16'h8000, 16'h0001, 16'h0001);
    send_payload(8'h00);
    send_payload(8'h80);                              // stray after close
    send_start(8'h7F, 16'h00FF, 16'hFF00, 16'h0002);
    send_payload(8'hFF);
    send_payload(8'h7F);
    send_start(8'h80, 16'h1234, 16'hABCD, 16'h0003);
    send_payload(8'h55);
    send_start(8'h5A, 16'hFFFF, 16'h0000, 16'hFFFF);  // abandons open packet, clamps
    send_payload(8'hAA);
    send_payload(8'h01);
    send_start(8'hC3, 16'h0001, 16'h8000, 16'h0100);  // just above the clamp
    send_payload(8'hFE);
    send_start(8'h3C, 16'h7FFF, 16'h7FFF, 16'h00FF);
    send_start(8'h10, 16'h0100, 16'h00FF, 16'h0001);
    send_payload(8'h00);
    send_start(8'h22, 16'hA5A5, 16'h5A5A, 16'h0005);
    send_payload(8'h00);
    send_payload(8'hFF);
    send_payload(8'h55);
    send_payload(8'hAA);
    send_payload(8'h01);
    wait_drained();

    write_sync(16'h0000);
    rx_mode   <= RX_SLOW;
    gap_max   = 2;
    burst_max = 4;
    random_traffic(45);
    wait_drained();

    // long receiver hold-off with the sender flat out
    write_sync(16'($urandom));
    rx_mode        <= RX_RANDOM;
    hold_off_asked <= hold_off_asked + 1;
    gap_max   = 0;
    burst_max = 1;
    random_traffic(45);
    wait_drained();

    // one full packet at the clamped length
    write_sync(16'h8001);
    rx_mode   <= RX_PATTERN;
    gap_max   = 6;
    burst_max = 10;
    send_start(8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom_range(256, 65535)));
    repeat (pkfr_pkg::MAX_PAYLOAD) send_payload(8'($urandom));
    random_traffic(30);
    wait_drained();

    // no idling on either side
    write_sync(16'($urandom));
    rx_mode <= RX_ALWAYS;
    gap_max = 0;
    if (items_sent < ITEM_TARGET) random_traffic(ITEM_TARGET - items_sent);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("tb_top: %0d input transactions (%0d starts, %0d ignored bytes), %0d wire bytes",
             items_sent + strays_sent, starts_sent, strays_sent, bytes_checked);
    $display("tb_top: five sync word settings incl. all-zero and all-one, %0d-cycle hold-off",
             HOLD_OFF_CYCLES);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
